### hdl/cba_pkg.sv
// Shared types and codes for the circuit breaker admission unit.
package cba_pkg;

   localparam int CFG_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [1:0] REQ_ACQUIRE = 2'd0;
   localparam logic [1:0] REQ_RELEASE = 2'd1;
   localparam logic [1:0] REQ_RESULT  = 2'd2;

   localparam logic [1:0] ST_CLOSED = 2'd0;
   localparam logic [1:0] ST_OPEN   = 2'd1;
   localparam logic [1:0] ST_HALF   = 2'd2;

   localparam logic [1:0] ADM_OK    = 2'd0;
   localparam logic [1:0] ADM_OPEN  = 2'd1;
   localparam logic [1:0] ADM_LIMIT = 2'd2;
   localparam logic [1:0] ADM_NONE  = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_CONCURRENT    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FAILURE_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OPEN_DURATION     = 2'd2;

   localparam logic [7:0] FAIL_RUN_MAX = 8'd255;

   // breaker state other than the open timestamp, whose width is a parameter
   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] active;
      logic [7:0]  fail_run;
      logic        probe;
   } brk_state_type;

   typedef struct packed {
      logic [15:0] max_concurrent;
      logic [7:0]  failure_threshold;
      logic [31:0] open_duration;
   } brk_cfg_type;

   typedef struct packed {
      logic [1:0]  admission;
      logic [1:0]  circuit_state;
      logic [15:0] active_count;
   } brk_result_type;

endpackage

### hdl/cba_core.sv
// Next-state and result logic for one breaker event.
module cba_core
   import cba_pkg::*;
#(
   parameter int TIME_WIDTH = 32
) (
   input  brk_state_type          cur_state,
   input  logic [TIME_WIDTH-1:0]  cur_opened,
   input  brk_cfg_type            cfg,
   input  logic [1:0]             ev_type,
   input  logic                   ev_success,
   input  logic                   ev_transient,
   input  logic [31:0]            ev_now,
   output brk_state_type          nxt_state,
   output logic [TIME_WIDTH-1:0]  nxt_opened,
   output brk_result_type         result
);

   localparam int CMP_WIDTH = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

   logic [CMP_WIDTH-1:0]  now_ext;
   logic [TIME_WIDTH-1:0] now_t;
   logic [TIME_WIDTH-1:0] elapsed;
   logic                  expired;
   logic                  opened_set;
   logic                  seen_expired;
   logic [1:0]            acq_mode;
   logic [1:0]            adm;

   assign now_ext = CMP_WIDTH'(ev_now);
   assign now_t   = now_ext[TIME_WIDTH-1:0];
   assign elapsed = now_t - cur_opened;
   assign expired = CMP_WIDTH'(elapsed) >= CMP_WIDTH'(cfg.open_duration);
   // an open breaker past its hold time is treated as half-open by an acquire
   assign acq_mode = (cur_state.mode == ST_OPEN && expired) ? ST_HALF : cur_state.mode;

   always_comb begin
      nxt_state  = cur_state;
      nxt_opened = cur_opened;
      opened_set = 1'b0;
      adm        = ADM_NONE;
      case (ev_type)
         REQ_ACQUIRE: begin
            nxt_state.mode = acq_mode;
            if (cur_state.mode == ST_OPEN && !expired) begin
               adm = ADM_OPEN;
            end else if (acq_mode == ST_HALF && cur_state.probe) begin
               adm = ADM_OPEN;
            end else if (cur_state.active >= cfg.max_concurrent) begin
               adm = ADM_LIMIT;
            end else begin
               adm = ADM_OK;
               nxt_state.active = cur_state.active + 16'd1;
               if (acq_mode == ST_HALF) begin
                  nxt_state.probe = 1'b1;
               end
            end
         end
         REQ_RELEASE: begin
            if (cur_state.active != 16'd0) begin
               nxt_state.active = cur_state.active - 16'd1;
            end
         end
         REQ_RESULT: begin
            if (ev_success) begin
               nxt_state.fail_run = 8'd0;
               nxt_state.mode     = ST_CLOSED;
               nxt_state.probe    = 1'b0;
            end else if (!ev_transient) begin
               if (cur_state.mode == ST_HALF) begin
                  nxt_state.mode  = ST_CLOSED;
                  nxt_state.probe = 1'b0;
               end
            end else begin
               if (cur_state.fail_run != FAIL_RUN_MAX) begin
                  nxt_state.fail_run = cur_state.fail_run + 8'd1;
               end
               if (cur_state.mode == ST_HALF ||
                   nxt_state.fail_run >= cfg.failure_threshold) begin
                  nxt_state.mode  = ST_OPEN;
                  nxt_state.probe = 1'b0;
                  nxt_opened      = now_t;
                  opened_set      = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // freshly opened: elapsed is zero, so only a zero hold time has expired
   assign seen_expired = opened_set ? (cfg.open_duration == 32'd0) : expired;

   assign result.admission     = adm;
   assign result.circuit_state = (nxt_state.mode == ST_OPEN && seen_expired) ?
                                 ST_HALF : nxt_state.mode;
   assign result.active_count  = nxt_state.active;

endmodule

### hdl/circuit_breaker_admission_unit.sv
// Each event passes through the input register and then the result register.
// Throughput: one event per cycle unless the result is held; the breaker state updates in the
// same cycle the event moves from the input register into the result register.
// A held result backs up into the input register; once both are full the input stalls.
// Reset (synchronous, active high): breaker closed, counts and timestamp zero,
// registers back to limit 1, threshold 1, hold time 1000.
module circuit_breaker_admission_unit
   import cba_pkg::*;
#(
   parameter int TIME_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_type,
   input  logic                       req_success,
   input  logic                       req_transient,
   input  logic [31:0]                req_now_time,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_admission,
   output logic [1:0]                 rsp_circuit_state,
   output logic [15:0]                rsp_active_count,
   input  logic                       csr_wen,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_wdata
);

   brk_cfg_type           cfg_ff, cfg_in;
   brk_state_type         state_ff, state_in;
   logic [TIME_WIDTH-1:0] opened_ff, opened_in;

   logic                  s1_valid_ff;
   logic [1:0]            s1_type_ff;
   logic                  s1_success_ff;
   logic                  s1_transient_ff;
   logic [31:0]           s1_now_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   brk_result_type        rsp_ff, rsp_in;

   logic                  out_free;
   logic                  advance;
   logic                  load_s1;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign load_s1   = req_valid && !req_stall;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_MAX_CONCURRENT: begin
               cfg_in.max_concurrent = (csr_wdata[15:0] == 16'd0) ? 16'd1 : csr_wdata[15:0];
            end
            CSR_FAILURE_THRESHOLD: begin
               cfg_in.failure_threshold = (csr_wdata[7:0] == 8'd0) ? 8'd1 : csr_wdata[7:0];
            end
            CSR_OPEN_DURATION: begin
               cfg_in.open_duration = csr_wdata[31:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_concurrent    <= 16'd1;
         cfg_ff.failure_threshold <= 8'd1;
         cfg_ff.open_duration     <= 32'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_type_ff      <= req_type;
         s1_success_ff   <= req_success;
         s1_transient_ff <= req_transient;
         s1_now_ff       <= req_now_time;
      end
   end

   brk_state_type         core_state;
   logic [TIME_WIDTH-1:0] core_opened;

   cba_core #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .cur_state    (state_ff),
      .cur_opened   (opened_ff),
      .cfg          (cfg_ff),
      .ev_type      (s1_type_ff),
      .ev_success   (s1_success_ff),
      .ev_transient (s1_transient_ff),
      .ev_now       (s1_now_ff),
      .nxt_state    (core_state),
      .nxt_opened   (core_opened),
      .result       (rsp_in)
   );

   assign state_in     = advance ? core_state : state_ff;
   assign opened_in    = advance ? core_opened : opened_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode     <= ST_CLOSED;
         state_ff.active   <= 16'd0;
         state_ff.fail_run <= 8'd0;
         state_ff.probe    <= 1'b0;
         opened_ff         <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         opened_ff    <= opened_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_admission     = rsp_ff.admission;
   assign rsp_circuit_state = rsp_ff.circuit_state;
   assign rsp_active_count  = rsp_ff.active_count;

   // a probe is only ever outstanding while half-open
   a_probe_half : assert property (@(posedge clock) disable iff (reset)
      state_ff.probe |-> state_ff.mode == ST_HALF)
      else $error("probe flag set outside half-open");

   // an admitted acquire always leaves at least one active request
   a_ok_active : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.admission == ADM_OK) |-> rsp_ff.active_count != 16'd0)
      else $error("accepted acquire reports zero active");

   // input side stalls only when the result register is full and held
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a held result");

   // active count changes only when an event advances
   a_active_step : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff.active))
      else $error("active count changed without an event");

endmodule
